[design/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is active.
`define VLN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define VLN_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/vln_pkg.sv]
package vln_pkg;

    localparam int COMPONENT_BITS   = 24;
    localparam int WEIGHT_FRAC_BITS = 8;
    localparam int UNIT_FRAC_BITS   = 14;

    localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 1;
    // blend sum: two products of weight and component plus the half
    localparam int BLEND_W  = COMPONENT_BITS + WEIGHT_FRAC_BITS + 3;
    localparam int M2_W     = 2 * COMPONENT_BITS;
    localparam int S_W      = 2 * COMPONENT_BITS + 2;
    localparam int Q_W      = UNIT_FRAC_BITS + 1;
    // holds (2q-1)^2 * s and |v|^2 << (2F+2), with sign
    localparam int ACC_W    = S_W + 2 * UNIT_FRAC_BITS + 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic FUNC_POSITION  = 1'b0;
    localparam logic FUNC_DIRECTION = 1'b1;

    typedef logic signed [COMPONENT_BITS-1:0] t_comp;

    // blended vector waiting for the back end
    typedef struct packed {
        logic  func;
        t_comp x;
        t_comp y;
        t_comp z;
    } t_item;

    // queue handshake from the front end
    typedef struct packed {
        logic full;
        logic push;
    } t_qctl;

endpackage

[design/vln_front.sv]
module vln_front import vln_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_func,
    input  t_comp               i_now_x,
    input  t_comp               i_now_y,
    input  t_comp               i_now_z,
    input  t_comp               i_prev_x,
    input  t_comp               i_prev_y,
    input  t_comp               i_prev_z,
    input  logic [WEIGHT_W-1:0] i_weight,
    input  logic                i_q_full,
    output t_qctl               o_qctl,
    output t_item               o_item
);

    localparam logic [WEIGHT_W-1:0] W_ONE = WEIGHT_W'(1 << WEIGHT_FRAC_BITS);
    localparam logic signed [BLEND_W-1:0] W_HALF =
        BLEND_W'(1 << (WEIGHT_FRAC_BITS - 1));

    logic                r_valid, n_valid;
    logic                r_func;
    t_comp               r_now [3];
    t_comp               r_prev [3];
    logic [WEIGHT_W-1:0] r_weight;

    logic                accept;
    logic [WEIGHT_W-1:0] w_sat, w_inv;
    logic signed [BLEND_W-1:0] t_sum [3];
    t_comp               v [3];

    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign n_valid = accept || (r_valid && i_q_full);

    assign o_qctl.push = r_valid && !i_q_full;
    assign o_qctl.full = i_q_full;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_func   <= i_func;
            r_now[0] <= i_now_x;
            r_now[1] <= i_now_y;
            r_now[2] <= i_now_z;
            r_prev[0] <= i_prev_x;
            r_prev[1] <= i_prev_y;
            r_prev[2] <= i_prev_z;
            r_weight <= i_weight;
        end
    end

    // blend, round half up, floor by shift
    always_comb begin
        w_sat = (r_weight > W_ONE) ? W_ONE : r_weight;
        w_inv = W_ONE - w_sat;
        for (int i = 0; i < 3; i++) begin
            t_sum[i] = $signed(BLEND_W'(w_sat)) * BLEND_W'(r_now[i])
                     + $signed(BLEND_W'(w_inv)) * BLEND_W'(r_prev[i])
                     + W_HALF;
            v[i] = (w_sat == '0) ? r_now[i]
                                 : t_sum[i][WEIGHT_FRAC_BITS +: COMPONENT_BITS];
        end
    end

    assign o_item.func = r_func;
    assign o_item.x    = v[0];
    assign o_item.y    = v[1];
    assign o_item.z    = v[2];

endmodule

[design/vln_queue.sv]
module vln_queue import vln_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_qctl i_qctl,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_qctl.push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)      r_rptr <= r_rptr + 1'b1;
            case ({i_qctl.push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_qctl.push) r_mem[r_wptr] <= i_item;
    end

endmodule

[design/vln_back.sv]
module vln_back import vln_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_item i_q_item,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_stall,
    output t_comp o_out_x,
    output t_comp o_out_y,
    output t_comp o_out_z,
    output logic  o_zero_length
);

    typedef struct packed {
        logic signed [ACC_W-1:0] e;  // (2q-1)^2 * s
        logic signed [ACC_W-1:0] f;  // (2q-1) * s
        logic signed [ACC_W-1:0] r;  // |v|^2 << (2F+2)
        logic [Q_W-1:0]          q;
    } t_lane;

    typedef struct packed {
        t_item          item;
        logic           zero;
        logic [S_W-1:0] s;
    } t_ctl;

    logic en;

    // squares stage
    logic                r1_valid;
    t_item               r1_item;
    logic [M2_W-1:0]     r1_m2 [3];
    t_comp               c_in [3];
    logic [COMPONENT_BITS-1:0] mag [3];

    // normalize pipeline: index 0 is the seed, index j+1 after bit F-j
    logic   r_st_valid [Q_W+1];
    t_ctl   r_st_ctl   [Q_W+1];
    t_lane  r_lane     [Q_W+1][3];
    t_lane  n_lane     [Q_W][3];
    t_ctl   n_seed;
    t_lane  n_seed_lane [3];

    // output register
    logic  r_o_valid;
    t_comp r_o_v [3];
    logic  r_o_zero;
    t_comp n_o_v [3];
    logic  n_o_zero;
    t_comp fin_v [3];

    assign en    = !(r_o_valid && i_stall);
    assign o_pop = en && i_q_valid;

    always_comb begin
        c_in[0] = i_q_item.x;
        c_in[1] = i_q_item.y;
        c_in[2] = i_q_item.z;
        for (int l = 0; l < 3; l++) begin
            mag[l] = c_in[l][COMPONENT_BITS-1] ? COMPONENT_BITS'(-c_in[l])
                                                : COMPONENT_BITS'(c_in[l]);
        end
    end

    // sum of squares, seed for the bit search
    always_comb begin
        logic [S_W-1:0] s_sum;
        s_sum = S_W'(r1_m2[0]) + S_W'(r1_m2[1]) + S_W'(r1_m2[2]);
        n_seed.item = r1_item;
        n_seed.s    = s_sum;
        n_seed.zero = (s_sum == '0);
        for (int l = 0; l < 3; l++) begin
            n_seed_lane[l].e = $signed(ACC_W'(s_sum));
            n_seed_lane[l].f = -$signed(ACC_W'(s_sum));
            n_seed_lane[l].r = $signed(ACC_W'(r1_m2[l])) <<< (2 * UNIT_FRAC_BITS + 2);
            n_seed_lane[l].q = '0;
        end
    end

    // one quotient bit per stage: keep q+b while (2(q+b)-1)^2 * s <= r
    always_comb begin
        logic signed [ACC_W-1:0] sx;
        logic signed [ACC_W-1:0] ec;
        for (int j = 0; j < Q_W; j++) begin
            sx = $signed(ACC_W'(r_st_ctl[j].s));
            for (int l = 0; l < 3; l++) begin
                n_lane[j][l] = r_lane[j][l];
                ec = r_lane[j][l].e + (r_lane[j][l].f <<< (UNIT_FRAC_BITS - j + 2))
                   + (sx <<< (2 * (UNIT_FRAC_BITS - j) + 2));
                if (!r_lane[j][l].q[UNIT_FRAC_BITS] && (ec <= r_lane[j][l].r)) begin
                    n_lane[j][l].e = ec;
                    n_lane[j][l].f = r_lane[j][l].f + (sx <<< (UNIT_FRAC_BITS - j + 1));
                    n_lane[j][l].q = r_lane[j][l].q | Q_W'(1 << (UNIT_FRAC_BITS - j));
                end
            end
        end
    end

    // result select
    always_comb begin
        fin_v[0] = r_st_ctl[Q_W].item.x;
        fin_v[1] = r_st_ctl[Q_W].item.y;
        fin_v[2] = r_st_ctl[Q_W].item.z;
        n_o_zero = 1'b0;
        for (int l = 0; l < 3; l++) begin
            n_o_v[l] = fin_v[l];
        end
        if (r_st_ctl[Q_W].item.func == FUNC_DIRECTION) begin
            if (r_st_ctl[Q_W].zero) begin
                n_o_zero = 1'b1;
                for (int l = 0; l < 3; l++) n_o_v[l] = '0;
            end else begin
                for (int l = 0; l < 3; l++) begin
                    n_o_v[l] = fin_v[l][COMPONENT_BITS-1]
                             ? -$signed(COMPONENT_BITS'(r_lane[Q_W][l].q))
                             :  $signed(COMPONENT_BITS'(r_lane[Q_W][l].q));
                end
            end
        end
    end

    // valid chain, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r_o_valid <= 1'b0;
            for (int j = 0; j <= Q_W; j++) r_st_valid[j] <= 1'b0;
        end else if (en) begin
            r1_valid      <= o_pop;
            r_st_valid[0] <= r1_valid;
            for (int j = 0; j < Q_W; j++) r_st_valid[j+1] <= r_st_valid[j];
            r_o_valid     <= r_st_valid[Q_W];
        end
    end

    // payload, moves with the pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_item <= i_q_item;
            for (int l = 0; l < 3; l++) r1_m2[l] <= mag[l] * mag[l];
            r_st_ctl[0] <= n_seed;
            for (int l = 0; l < 3; l++) r_lane[0][l] <= n_seed_lane[l];
            for (int j = 0; j < Q_W; j++) begin
                r_st_ctl[j+1] <= r_st_ctl[j];
                for (int l = 0; l < 3; l++) r_lane[j+1][l] <= n_lane[j][l];
            end
            if (r_st_valid[Q_W]) begin
                for (int l = 0; l < 3; l++) r_o_v[l] <= n_o_v[l];
                r_o_zero <= n_o_zero;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_x       = r_o_v[0];
    assign o_out_y       = r_o_v[1];
    assign o_out_z       = r_o_v[2];
    assign o_zero_length = r_o_zero;

endmodule

[design/vector_lerp_normalize_core.sv]
// Blends a current and a previous 3-vector by a weight in 1/256 steps and,
// for directions, scales the blend to a unit vector in Q1.14.
// Input channel: i_valid / o_stall with the fields on i_* ports; an item is
// taken on a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall; a result leaves on an edge with o_valid
// high and i_stall low. While i_stall is high the result holds.
// Throughput: one item per cycle while neither i_stall nor o_stall holds
// the flow. From acceptance to o_valid an item passes the input register
// and blend, a 4-entry queue, a squares stage, a sum stage, one stage per
// quotient bit of the unit search, and the output register.
// The front end keeps accepting while the back end is stalled until the
// queue fills; o_stall then rises.
// Reset (i_rst_n low, synchronous) empties the queue and drops all items in
// flight; no clearing pass is needed afterwards.
module vector_lerp_normalize_core import vln_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_func,
    input  t_comp               i_now_x,
    input  t_comp               i_now_y,
    input  t_comp               i_now_z,
    input  t_comp               i_prev_x,
    input  t_comp               i_prev_y,
    input  t_comp               i_prev_z,
    input  logic [WEIGHT_W-1:0] i_weight,
    output logic                o_valid,
    input  logic                i_stall,
    output t_comp               o_out_x,
    output t_comp               o_out_y,
    output t_comp               o_out_z,
    output logic                o_zero_length
);

    t_qctl qctl;
    t_item f_item, q_item;
    logic  q_full, q_valid, pop;

    vln_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_func   (i_func),
        .i_now_x  (i_now_x),
        .i_now_y  (i_now_y),
        .i_now_z  (i_now_z),
        .i_prev_x (i_prev_x),
        .i_prev_y (i_prev_y),
        .i_prev_z (i_prev_z),
        .i_weight (i_weight),
        .i_q_full (q_full),
        .o_qctl   (qctl),
        .o_item   (f_item)
    );

    vln_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qctl  (qctl),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    vln_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_zero_length (o_zero_length)
    );

endmodule

[design/vln_checker.sv]
`include "assert_macros.svh"

module vln_checker import vln_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  o_stall,
    input logic  o_valid,
    input logic  i_stall,
    input t_comp o_out_x,
    input t_comp o_out_y,
    input t_comp o_out_z,
    input logic  o_zero_length
);

    // a stalled result stays offered and unchanged
    `VLN_ASSERT(a_out_hold, (o_valid && i_stall) |=> (o_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z) && $stable(o_zero_length)), "output changed while stalled")

    // a zero-length flag comes with an all-zero vector
    `VLN_ASSERT(a_zero_vec, (o_valid && o_zero_length) |-> (o_out_x == '0 && o_out_y == '0 && o_out_z == '0), "zero length with nonzero output")

    // nothing is offered in the cycle after reset
    `VLN_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!o_valid && !o_stall), "output or stall live after reset")

    // the queue cannot be full right after an idle back end drained it
    `VLN_ASSERT(a_stall_needs_backlog, ($rose(o_stall)) |-> ($past(o_valid) && $past(i_stall)), "input stalled with no output backlog")

endmodule

bind vector_lerp_normalize_core vln_checker u_vln_checker (.*);

[bench/vector_lerp_normalize_core_tb.sv]
`timescale 1ns / 1ps

module vector_lerp_normalize_core_tb import vln_pkg::*; ;

    typedef struct {
        t_comp x;
        t_comp y;
        t_comp z;
        logic  zero_length;
    } t_unit_result;

    // Predicts the blended or normalized vector and holds what is still due
    class lerp_scoreboard;
        t_unit_result pending[$];
        int           mismatches = 0;

        function automatic longint blend_comp(longint now_c, longint prev_c, longint w);
            longint t;
            longint q;
            t = w * now_c + ((1 << WEIGHT_FRAC_BITS) - w) * prev_c
                + (1 << (WEIGHT_FRAC_BITS - 1));
            q = t / (1 << WEIGHT_FRAC_BITS);
            if ((t % (1 << WEIGHT_FRAC_BITS)) != 0 && t < 0) q = q - 1;
            return q;
        endfunction

        // largest q <= 2^F with (2q-1)^2 * s <= m^2 * 2^(2F+2)
        function automatic longint unit_mag(longint m, longint s);
            logic [127:0] rhs;
            logic [127:0] lhs;
            longint       q;
            longint       c;
            rhs = 128'(m) * 128'(m);
            rhs = rhs << (2 * UNIT_FRAC_BITS + 2);
            q = 0;
            for (int b = UNIT_FRAC_BITS; b >= 0; b--) begin
                c = q | (longint'(1) << b);
                if (c <= (longint'(1) << UNIT_FRAC_BITS)) begin
                    lhs = 128'(2 * c - 1) * 128'(2 * c - 1) * 128'(s);
                    if (lhs <= rhs) q = c;
                end
            end
            return q;
        endfunction

        function void note_item(logic func, t_comp nx, t_comp ny, t_comp nz,
                                t_comp px, t_comp py, t_comp pz,
                                logic [WEIGHT_W-1:0] weight);
            longint       v[3];
            longint       n[3];
            longint       p[3];
            longint       mag[3];
            longint       w;
            longint       s;
            longint       r[3];
            t_unit_result res;
            n[0] = nx; n[1] = ny; n[2] = nz;
            p[0] = px; p[1] = py; p[2] = pz;
            w = weight;
            if (w > (1 << WEIGHT_FRAC_BITS)) w = 1 << WEIGHT_FRAC_BITS;
            for (int i = 0; i < 3; i++)
                v[i] = (w == 0) ? n[i] : blend_comp(n[i], p[i], w);
            res.zero_length = 1'b0;
            if (func == FUNC_POSITION) begin
                r = v;
            end else begin
                s = 0;
                for (int i = 0; i < 3; i++) begin
                    mag[i] = (v[i] < 0) ? -v[i] : v[i];
                    s += mag[i] * mag[i];
                end
                if (s == 0) begin
                    r[0] = 0; r[1] = 0; r[2] = 0;
                    res.zero_length = 1'b1;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        r[i] = unit_mag(mag[i], s);
                        if (v[i] < 0) r[i] = -r[i];
                    end
                end
            end
            res.x = t_comp'(r[0]);
            res.y = t_comp'(r[1]);
            res.z = t_comp'(r[2]);
            pending.push_back(res);
        endfunction

        function void check_result(t_comp x, t_comp y, t_comp z, logic zl);
            t_unit_result e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %0d %0d %0d %0b", x, y, z, zl);
                return;
            end
            e = pending.pop_front();
            if (x !== e.x || y !== e.y || z !== e.z || zl !== e.zero_length) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                             e.x, e.y, e.z, e.zero_length, x, y, z, zl);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_func;
    t_comp               i_now_x, i_now_y, i_now_z;
    t_comp               i_prev_x, i_prev_y, i_prev_z;
    logic [WEIGHT_W-1:0] i_weight;
    logic                o_valid;
    logic                i_stall;
    t_comp               o_out_x, o_out_y, o_out_z;
    logic                o_zero_length;

    lerp_scoreboard board;
    int             send_idle_pct;
    int             recv_stall_pct;
    longint         cycle_count;

    vector_lerp_normalize_core dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side: stall at random, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_out_x, o_out_y, o_out_z, o_zero_length);
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Drive one item; hold until accepted. Valid stays high for a following item.
    task automatic send_item(logic func, t_comp nx, t_comp ny, t_comp nz,
                             t_comp px, t_comp py, t_comp pz, logic [WEIGHT_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_func   <= func;
        i_now_x  <= nx; i_now_y <= ny; i_now_z <= nz;
        i_prev_x <= px; i_prev_y <= py; i_prev_z <= pz;
        i_weight <= w;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        board.note_item(func, nx, ny, nz, px, py, pz, w);
        @(negedge i_clk);
    endtask

    function automatic t_comp rand_comp();
        case ($urandom_range(5))
            0: return t_comp'($urandom);
            1: return t_comp'($signed($urandom_range(200)) - 100);
            2: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
            3: return 24'sd0;
            default: return t_comp'($signed($urandom_range(131072)) - 65536);
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(5))
            0: return '0;
            1: return WEIGHT_W'(256);
            2: return WEIGHT_W'($urandom);
            default: return WEIGHT_W'($urandom_range(256));
        endcase
    endfunction

    task automatic send_random(int count);
        logic  zero_dir;
        t_comp nx, ny, nz;
        for (int k = 0; k < count; k++) begin
            zero_dir = ($urandom_range(19) == 0);
            nx = zero_dir ? 24'sd0 : rand_comp();
            ny = zero_dir ? 24'sd0 : rand_comp();
            nz = zero_dir ? 24'sd0 : rand_comp();
            if (zero_dir)
                send_item(1'b1, nx, ny, nz, rand_comp(), rand_comp(), rand_comp(), '0);
            else
                send_item(1'(($urandom_range(2)) != 0), nx, ny, nz,
                          rand_comp(), rand_comp(), rand_comp(), rand_weight());
        end
    endtask

    // stop sending and wait for every due result
    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        board = new();
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_stall  = 1'b0;
        i_func   = FUNC_POSITION;
        i_now_x  = '0; i_now_y = '0; i_now_z = '0;
        i_prev_x = '0; i_prev_y = '0; i_prev_z = '0;
        i_weight = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, both functions, zero weight, full and oversize weight
        send_item(FUNC_POSITION, 24'sh7fffff, 24'sh800000, 0, 24'sh800000, 24'sh7fffff, 1, 0);
        send_item(FUNC_POSITION, 24'sh7fffff, 24'sh800000, 0, 24'sh800000, 24'sh7fffff, 1, 128);
        send_item(FUNC_POSITION, 24'sh7fffff, 24'sh800000, -1, 24'sh800000, 24'sh7fffff, 1, 256);
        send_item(FUNC_POSITION, 3, -3, 5, -4, 4, 2, 9'h1ff);
        send_item(FUNC_POSITION, 1, -1, 0, 0, 0, -1, 1);
        send_item(FUNC_POSITION, -1, 1, 0, 0, 0, 0, 255);
        send_item(FUNC_DIRECTION, 0, 0, 0, 5, 6, 7, 0);
        send_item(FUNC_DIRECTION, 5, 5, 5, -5, -5, -5, 128);
        send_item(FUNC_DIRECTION, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0, 0, 0, 0);
        send_item(FUNC_DIRECTION, 24'sh800000, 24'sh800000, 24'sh800000, 0, 0, 0, 300);
        send_item(FUNC_DIRECTION, 1, 0, 0, 0, 0, 0, 0);
        send_item(FUNC_DIRECTION, 0, -1, 0, 0, 0, 0, 0);
        send_item(FUNC_DIRECTION, 3, 4, 0, 0, 0, 0, 0);
        send_item(FUNC_DIRECTION, 1, 1, 1, 1, 1, 1, 77);
        send_item(FUNC_DIRECTION, 24'sh7fffff, 1, -1, 24'sh800000, -1, 1, 256);
        send_item(FUNC_DIRECTION, 1, 0, 0, 0, 0, 0, 1);
        // hold off until every result is back
        drain();

        send_random(120);
        send_idle_pct = 64;
        send_random(120);
        send_idle_pct = 0;
        recv_stall_pct = 64;
        send_random(120);
        send_idle_pct = 24;
        recv_stall_pct = 24;
        send_random(120);

        drain();
        recv_stall_pct = 0;
        repeat (40) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
